// File: src/ick_pkg.sv
`timescale 1ns / 1ps

package ick_pkg;

    // frame store geometry
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int KERNEL_SIZE = 5;

    // field widths
    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 7;
    localparam int RGB_W   = 3 * PIX_W;
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

    // kernel layout: 5x5 grid, center at row and column 2
    localparam int KDIM    = 5;
    localparam int KCTR    = KDIM / 2;
    localparam int KHALF   = KERNEL_SIZE / 2;
    localparam int TAPS    = KDIM * KDIM;
    localparam int TAP_W   = 5;
    localparam int KPOS_W  = 3;

    // datapath widths
    localparam int ACC_W   = 21;
    localparam int MAG_W   = 20;
    localparam int DIV_W   = 8;
    localparam int RES_W   = 22;
    localparam int STEP_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0_7      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_8_15     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_16_23    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP24_DIV_BIAS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

    // item actions
    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

// File: src/ick_if.sv
`timescale 1ns / 1ps

// pixel item channel: store or compute request
interface ick_pix_if
    import ick_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, action, col, row, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, action, col, row, red_in, green_in, blue_in,
                    output ready);
endinterface

// filtered pixel result channel
interface ick_res_if
    import ick_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, out_col, out_row, red_out, green_out, blue_out,
                    input ready);
    modport sink   (input valid, out_col, out_row, red_out, green_out, blue_out,
                    output ready);
endinterface

// register write channel
interface ick_cfg_if
    import ick_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/ick_ram.sv
`timescale 1ns / 1ps

module ick_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/image_convolution_kernel_wrap.sv
`timescale 1ns / 1ps

// channel   modport  handshake      payload
// pix_in    sink     valid/ready    action, col, row, red_in, green_in, blue_in
// res_out   source   valid/ready    out_col, out_row, red_out, green_out, blue_out
// cfg       sink     valid/ready    index, data (ready always high)
//
// a store writes the frame store on its transfer; a compute holds pix_in.ready
// low until it returns to idle, through 6 remainder steps, a tap phase (25 frame
// store reads, each accumulated after its registered read, and a closing step),
// one load step, 20 shift-subtract divider steps and a step that loads the result.
// reset sets control state and configuration to defaults; frame store not cleared.
// pix_in stays ready in idle while a result waits, so stores go on; a finished
// compute holds in its last state until the result register is free.

module image_convolution_kernel_wrap
    import ick_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ick_pix_if.sink   pix_in,
    ick_res_if.source res_out,
    ick_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_TAPS,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    // neighbour coordinate with full wrap, offset is tap position minus center
    function automatic logic [COL_W-1:0] wrap_pos(
        input logic [COL_W-1:0]  c,
        input logic [KPOS_W-1:0] t,
        input logic [SIZE_W-1:0] size
    );
        logic signed [SIZE_W+1:0] p;
        logic signed [SIZE_W+1:0] s;
        p = $signed({3'b000, c}) + $signed({{(SIZE_W-1){1'b0}}, t})
            - $signed((SIZE_W+2)'(KCTR));
        s = $signed({2'b00, size});
        if (p < 0)
        begin
            p = p + s;
        end
        if (p < 0)
        begin
            p = p + s;
        end
        if (p >= s)
        begin
            p = p - s;
        end
        if (p >= s)
        begin
            p = p - s;
        end
        return p[COL_W-1:0];
    endfunction

    // control and configuration
    state_t                state_reg, state_next;
    logic [CFG_DATA_W-1:0] coef0_reg, coef1_reg, coef2_reg;
    logic [RGB_W-1:0]      tdb_reg;
    logic [SIZE_W-1:0]     fw_reg, fh_reg;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [KPOS_W-1:0]     tx_reg, tx_next, ty_reg, ty_next;
    logic [TAP_W-1:0]      tap_reg, tap_next;
    logic                  iss_done_reg, iss_done_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [TAP_W-1:0]      rd_tap_reg, rd_tap_next;
    logic [KPOS_W-1:0]     rd_tx_reg, rd_tx_next, rd_ty_reg, rd_ty_next;
    logic                  out_vld_reg, out_vld_next;

    // item payload and working values
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      colsh_reg, colsh_next;
    logic [ROW_W-1:0]      rowsh_reg, rowsh_next;
    logic [SIZE_W-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic [MAG_W-1:0]      dvd_reg [3];
    logic [MAG_W-1:0]      dvd_next [3];
    logic [DIV_W-1:0]      rem_reg [3];
    logic [DIV_W-1:0]      rem_next [3];
    logic [2:0]            neg_reg, neg_next;
    logic [COL_W-1:0]      ocol_reg, ocol_next;
    logic [ROW_W-1:0]      orow_reg, orow_next;
    logic [PIX_W-1:0]      opix_reg [3];
    logic [PIX_W-1:0]      opix_next [3];

    // combinational helpers
    logic                    in_xfer, cfg_xfer, res_free;
    logic [SIZE_W-1:0]       fw_sat, fh_sat;
    logic [TAPS-1:0][PIX_W-1:0] taps;
    logic signed [PIX_W-1:0] kval, dsig, bias;
    logic signed [DIV_W:0]   dwide;
    logic [DIV_W-1:0]        dmag;
    logic                    dneg, in_kern;
    logic [SIZE_W-1:0]       trial_x, trial_y;
    logic [RGB_W-1:0]        rd_data;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COL_W-1:0]        nb_x;
    logic [ROW_W-1:0]        nb_y;
    logic                    st_we;

    assign in_xfer  = pix_in.valid && pix_in.ready;
    assign cfg_xfer = cfg.valid && cfg.ready;
    assign res_free = !out_vld_reg || res_out.ready;

    assign pix_in.ready    = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign res_out.valid   = out_vld_reg;
    assign res_out.out_col = ocol_reg;
    assign res_out.out_row = orow_reg;
    assign res_out.red_out   = opix_reg[0];
    assign res_out.green_out = opix_reg[1];
    assign res_out.blue_out  = opix_reg[2];

    // frame size saturated to 1..max
    assign fw_sat = (fw_reg == '0) ? SIZE_W'(1) :
                    (fw_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : fw_reg;
    assign fh_sat = (fh_reg == '0) ? SIZE_W'(1) :
                    (fh_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : fh_reg;

    // kernel taps, divisor and bias
    assign taps  = {tdb_reg[PIX_W-1:0], coef2_reg, coef1_reg, coef0_reg};
    assign dsig  = (tdb_reg[2*PIX_W-1:PIX_W] == '0) ? PIX_W'(1)
                                                    : $signed(tdb_reg[2*PIX_W-1:PIX_W]);
    assign bias  = $signed(tdb_reg[3*PIX_W-1:2*PIX_W]);
    assign dneg  = dsig[PIX_W-1];
    assign dwide = dneg ? -$signed({dsig[PIX_W-1], dsig}) : $signed({dsig[PIX_W-1], dsig});
    assign dmag  = dwide[DIV_W-1:0];
    assign in_kern = (int'(rd_tx_reg) >= KCTR - KHALF) && (int'(rd_tx_reg) <= KCTR + KHALF)
                  && (int'(rd_ty_reg) >= KCTR - KHALF) && (int'(rd_ty_reg) <= KCTR + KHALF);
    assign kval  = in_kern ? $signed(taps[rd_tap_reg]) : '0;

    // remainder trial bits for the center coordinate
    assign trial_x = {cx_reg[SIZE_W-2:0], colsh_reg[COL_W-1]};
    assign trial_y = {cy_reg[SIZE_W-2:0], rowsh_reg[ROW_W-1]};

    // neighbour address
    assign nb_x    = wrap_pos(cx_reg[COL_W-1:0], tx_reg, fw_sat);
    assign nb_y    = wrap_pos(cy_reg[ROW_W-1:0], ty_reg, fh_sat);
    assign rd_addr = {nb_y, nb_x};

    // store writes
    assign st_we = in_xfer && (pix_in.action == ACT_STORE)
                && ({1'b0, pix_in.col} < SIZE_W'(MAX_WIDTH))
                && ({1'b0, pix_in.row} < SIZE_W'(MAX_HEIGHT));

    ick_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (st_we),
        .waddr ({pix_in.row, pix_in.col}),
        .wdata ({pix_in.blue_in, pix_in.green_in, pix_in.red_in}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // sequencer and datapath next values
    always_comb
    begin
        logic signed [PIX_W+PIX_W:0] prod;
        logic [DIV_W:0]              trial;
        logic                        ge;
        logic signed [RES_W-1:0]     q;
        logic signed [RES_W-1:0]     v;

        state_next    = state_reg;
        step_next     = step_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        tap_next      = tap_reg;
        iss_done_next = iss_done_reg;
        rd_vld_next   = 1'b0;
        rd_tap_next   = tap_reg;
        rd_tx_next    = tx_reg;
        rd_ty_next    = ty_reg;
        out_vld_next  = out_vld_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        colsh_next    = colsh_reg;
        rowsh_next    = rowsh_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        neg_next      = neg_reg;
        ocol_next     = ocol_reg;
        orow_next     = orow_reg;
        prod          = '0;
        trial         = '0;
        ge            = 1'b0;
        q             = '0;
        v             = '0;
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c]  = acc_reg[c];
            dvd_next[c]  = dvd_reg[c];
            rem_next[c]  = rem_reg[c];
            opix_next[c] = opix_reg[c];
        end

        // result taken
        if (out_vld_reg && res_out.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (pix_in.action == ACT_COMPUTE))
                begin
                    col_next   = pix_in.col;
                    row_next   = pix_in.row;
                    colsh_next = pix_in.col;
                    rowsh_next = pix_in.row;
                    cx_next    = '0;
                    cy_next    = '0;
                    step_next  = '0;
                    state_next = S_WRAP;
                end
            end

            // restoring remainder, one bit of col and row per cycle
            S_WRAP:
            begin
                cx_next    = (trial_x >= fw_sat) ? trial_x - fw_sat : trial_x;
                cy_next    = (trial_y >= fh_sat) ? trial_y - fh_sat : trial_y;
                colsh_next = {colsh_reg[COL_W-2:0], 1'b0};
                rowsh_next = {rowsh_reg[ROW_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_W'(COL_W - 1))
                begin
                    tx_next       = '0;
                    ty_next       = '0;
                    tap_next      = '0;
                    iss_done_next = 1'b0;
                    for (int c = 0; c < 3; c++)
                    begin
                        acc_next[c] = '0;
                    end
                    state_next = S_TAPS;
                end
            end

            // one frame store read issued per cycle, accumulated in the following cycle
            S_TAPS:
            begin
                if (!iss_done_reg)
                begin
                    rd_vld_next = 1'b1;
                    tap_next    = tap_reg + 1'b1;
                    if (tx_reg == KPOS_W'(KDIM - 1))
                    begin
                        tx_next = '0;
                        ty_next = ty_reg + 1'b1;
                        if (ty_reg == KPOS_W'(KDIM - 1))
                        begin
                            iss_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tx_next = tx_reg + 1'b1;
                    end
                end
                if (rd_vld_reg)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod = $signed({1'b0, rd_data[c*PIX_W +: PIX_W]}) * kval;
                        acc_next[c] = acc_reg[c] + ACC_W'(prod);
                    end
                end
                if (iss_done_reg && !rd_vld_reg)
                begin
                    state_next = S_LOAD;
                end
            end

            // split sums into sign and magnitude for the divider
            S_LOAD:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    neg_next[c] = acc_reg[c][ACC_W-1] ^ dneg;
                    dvd_next[c] = acc_reg[c][ACC_W-1] ? MAG_W'(-acc_reg[c])
                                                      : MAG_W'(acc_reg[c]);
                    rem_next[c] = '0;
                end
                step_next  = '0;
                state_next = S_DIV;
            end

            // shift-subtract divider, one quotient bit per lane per cycle
            S_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    trial = {rem_reg[c], dvd_reg[c][MAG_W-1]};
                    ge    = (trial >= {1'b0, dmag});
                    rem_next[c] = ge ? DIV_W'(trial - {1'b0, dmag}) : trial[DIV_W-1:0];
                    dvd_next[c] = {dvd_reg[c][MAG_W-2:0], ge};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = S_DONE;
                end
            end

            // sign, bias and clamp into the result register
            S_DONE:
            begin
                if (res_free)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        q = neg_reg[c] ? -$signed({2'b00, dvd_reg[c]})
                                       : $signed({2'b00, dvd_reg[c]});
                        v = q + RES_W'(bias);
                        if (v < 0)
                        begin
                            opix_next[c] = '0;
                        end
                        else if (v > $signed(RES_W'(PIX_MAX)))
                        begin
                            opix_next[c] = PIX_MAX;
                        end
                        else
                        begin
                            opix_next[c] = v[PIX_W-1:0];
                        end
                    end
                    ocol_next    = col_reg;
                    orow_next    = row_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            coef0_reg    <= '0;
            coef1_reg    <= '0;
            coef2_reg    <= '0;
            tdb_reg      <= RGB_W'(256);
            fw_reg       <= SIZE_W'(MAX_WIDTH);
            fh_reg       <= SIZE_W'(MAX_HEIGHT);
            step_reg     <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            tap_reg      <= '0;
            iss_done_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            tx_reg       <= tx_next;
            ty_reg       <= ty_next;
            tap_reg      <= tap_next;
            iss_done_reg <= iss_done_next;
            rd_vld_reg   <= rd_vld_next;
            out_vld_reg  <= out_vld_next;
            rd_tap_reg   <= rd_tap_next;
            rd_tx_reg    <= rd_tx_next;
            rd_ty_reg    <= rd_ty_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            colsh_reg    <= colsh_next;
            rowsh_reg    <= rowsh_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            neg_reg      <= neg_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c]  <= acc_next[c];
                dvd_reg[c]  <= dvd_next[c];
                rem_reg[c]  <= rem_next[c];
                opix_reg[c] <= opix_next[c];
            end

            // register writes, unknown index ignored
            if (cfg_xfer)
            begin
                case (cfg.index)
                    REG_COEF_0_7:       coef0_reg <= cfg.data;
                    REG_COEF_8_15:      coef1_reg <= cfg.data;
                    REG_COEF_16_23:     coef2_reg <= cfg.data;
                    REG_TAP24_DIV_BIAS: tdb_reg   <= cfg.data[RGB_W-1:0];
                    REG_FRAME_WIDTH:    fw_reg    <= cfg.data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT:   fh_reg    <= cfg.data[SIZE_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

endmodule
